// ----- rtl/jse_pkg.sv -----
// shared types, constants and state codes of the jacobi eigen solver
package jse_pkg;

  localparam int unsigned MaxN    = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned AddrW   = 2 * IdxW;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CntW    = 13;
  localparam int unsigned SizeW   = 5;
  localparam int unsigned ThrW    = 33;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  localparam logic [CfgIdxW-1:0] CFG_MATRIX_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD   = 2'd1;

  // rotation coefficients, Q2.30
  typedef struct packed {
    logic signed [ValW-1:0] c;
    logic signed [ValW-1:0] s;
    logic signed [ValW-1:0] cs;
    logic signed [ValW-1:0] c2;
    logic signed [ValW-1:0] s2;
  } coef_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_SDRAIN, ST_SQ, ST_CHK, ST_RLD, ST_COEF,
    ST_ROT, ST_DIAG, ST_ORD, ST_OLD
  } state_e;

  typedef enum logic [3:0] {
    CF_IDLE, CF_SQ1, CF_SQ2, CF_SQRT, CF_DIV, CF_T2, CF_SM, CF_C2,
    CF_S2, CF_CS, CF_DONE
  } coef_state_e;

endpackage

// ----- rtl/jse_ram.sv -----
// single write, single read synchronous ram with registered read data
module jse_ram #(
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/jse_coef.sv -----
// rotation coefficient unit: shared multiplier, bit-serial square root and divider
module jse_coef (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [jse_pkg::ValW-1:0] akk_i,
  input  logic signed [jse_pkg::ValW-1:0] all_i,
  input  logic signed [jse_pkg::ValW-1:0] akl_i,
  output logic                        done_o,
  output jse_pkg::coef_t              coef_o
);
  import jse_pkg::*;

  coef_state_e state_q, state_d;
  logic        pass_q, pass_d;
  logic        neg_q, neg_d;
  logic [30:0] dm_q, dm_d, em_q, em_d;
  logic [61:0] acc_q, acc_d;
  logic [63:0] sv_q, sv_d, sr_q, sr_d, sb_q, sb_d;
  logic [34:0] rem_q, rem_d;
  logic [60:0] num_q, num_d, quo_q, quo_d;
  logic [33:0] den_q, den_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic [30:0] tm_q, tm_d, c_q, c_d, sm_q, sm_d, c2_q, c2_d, s2_q, s2_d, csm_q, csm_d;

  logic signed [32:0] d_w, e_w;
  logic [32:0] dmag, emag, ormag;
  logic [30:0] ma, mb;
  logic [61:0] mp, mrnd;
  logic [63:0] st_w, sv_n, sr_n;
  logic [34:0] rem2, rem_n;
  logic        ge;
  logic [60:0] quo_n;

  // magnitude prep from the pivot entries
  always_comb begin
    d_w   = {all_i[ValW-1], all_i} - {akk_i[ValW-1], akk_i};
    e_w   = {akl_i, 1'b0};
    dmag  = d_w[32] ? 33'(-d_w) : 33'(d_w);
    emag  = e_w[32] ? 33'(-e_w) : 33'(e_w);
    ormag = dmag | emag;
  end

  // shared multiplier and rounding to Q2.30
  assign mp   = 62'(ma) * 62'(mb);
  assign mrnd = mp + 62'h2000_0000;

  // one square root step
  always_comb begin
    st_w = sr_q + sb_q;
    if (sv_q >= st_w) begin
      sv_n = sv_q - st_w;
      sr_n = (sr_q >> 1) + sb_q;
    end else begin
      sv_n = sv_q;
      sr_n = sr_q >> 1;
    end
  end

  // one restoring division step
  always_comb begin
    rem2  = {rem_q[33:0], num_q[60]};
    ge    = rem2 >= {1'b0, den_q};
    rem_n = ge ? rem2 - {1'b0, den_q} : rem2;
    quo_n = {quo_q[59:0], ge};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    neg_d   = neg_q;
    dm_d    = dm_q;
    em_d    = em_q;
    acc_d   = acc_q;
    sv_d    = sv_q;
    sr_d    = sr_q;
    sb_d    = sb_q;
    rem_d   = rem_q;
    num_d   = num_q;
    quo_d   = quo_q;
    den_d   = den_q;
    dcnt_d  = dcnt_q;
    tm_d    = tm_q;
    c_d     = c_q;
    sm_d    = sm_q;
    c2_d    = c2_q;
    s2_d    = s2_q;
    csm_d   = csm_q;
    ma      = '0;
    mb      = '0;
    done_o  = 1'b0;
    unique case (state_q)
      CF_IDLE: begin
        if (start_i) begin
          if (ormag[32]) begin
            dm_d = dmag[32:2];
            em_d = emag[32:2];
          end else if (ormag[31]) begin
            dm_d = dmag[31:1];
            em_d = emag[31:1];
          end else begin
            dm_d = dmag[30:0];
            em_d = emag[30:0];
          end
          neg_d = ((!d_w[32] && d_w != '0) && e_w[32]) ||
                  (d_w[32] && (!e_w[32] && e_w != '0));
          state_d = CF_SQ1;
        end
      end
      CF_SQ1: begin
        ma = dm_q;
        mb = dm_q;
        acc_d = mp;
        state_d = CF_SQ2;
      end
      CF_SQ2: begin
        ma = em_q;
        mb = em_q;
        sv_d = 64'(acc_q) + 64'(mp);
        sr_d = '0;
        sb_d = 64'h4000_0000_0000_0000;
        pass_d = 1'b0;
        state_d = CF_SQRT;
      end
      CF_SQRT: begin
        sv_d = sv_n;
        sr_d = sr_n;
        sb_d = sb_q >> 2;
        if (sb_q == 64'd1) begin
          rem_d  = '0;
          quo_d  = '0;
          dcnt_d = '0;
          if (!pass_q) begin
            num_d = {em_q, 30'd0};
            den_d = 34'(dm_q) + sr_n[33:0];
          end else begin
            num_d = 61'h1000_0000_0000_0000;
            den_d = sr_n[33:0];
          end
          state_d = CF_DIV;
        end
      end
      CF_DIV: begin
        rem_d  = rem_n;
        quo_d  = quo_n;
        num_d  = {num_q[59:0], 1'b0};
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd60) begin
          if (!pass_q) begin
            tm_d = quo_n[30:0];
            state_d = CF_T2;
          end else begin
            c_d = quo_n[30:0];
            state_d = CF_SM;
          end
        end
      end
      CF_T2: begin
        ma = tm_q;
        mb = tm_q;
        sv_d = 64'h1000_0000_0000_0000 + 64'(mp);
        sr_d = '0;
        sb_d = 64'h4000_0000_0000_0000;
        pass_d = 1'b1;
        state_d = CF_SQRT;
      end
      CF_SM: begin
        ma = tm_q;
        mb = c_q;
        sm_d = mrnd[60:30];
        state_d = CF_C2;
      end
      CF_C2: begin
        ma = c_q;
        mb = c_q;
        c2_d = mrnd[60:30];
        state_d = CF_S2;
      end
      CF_S2: begin
        ma = sm_q;
        mb = sm_q;
        s2_d = mrnd[60:30];
        state_d = CF_CS;
      end
      CF_CS: begin
        ma = c_q;
        mb = sm_q;
        csm_d = mrnd[60:30];
        state_d = CF_DONE;
      end
      CF_DONE: begin
        done_o = 1'b1;
        state_d = CF_IDLE;
      end
      default: state_d = CF_IDLE;
    endcase
  end

  // signed coefficients
  always_comb begin
    coef_o.c  = {1'b0, c_q};
    coef_o.c2 = {1'b0, c2_q};
    coef_o.s2 = {1'b0, s2_q};
    coef_o.s  = neg_q ? -{1'b0, sm_q} : {1'b0, sm_q};
    coef_o.cs = neg_q ? -{1'b0, csm_q} : {1'b0, csm_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CF_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    dm_q   <= dm_d;
    em_q   <= em_d;
    acc_q  <= acc_d;
    sv_q   <= sv_d;
    sr_q   <= sr_d;
    sb_q   <= sb_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    dcnt_q <= dcnt_d;
    tm_q   <= tm_d;
    c_q    <= c_d;
    sm_q   <= sm_d;
    c2_q   <= c2_d;
    s2_q   <= s2_d;
    csm_q  <= csm_d;
  end

endmodule

// ----- rtl/jacobi_symmetric_eigen_solver_unit.sv -----
// top level: matrix store, pivot search, rotation sequencer and result port
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: row_index, col_index, entry_value; tlast: last_entry
//  m_axis   | out       | tdata: eigen_index, eigenvalue, iterations_used; tuser: converged;
//           |           | tlast: last_result
//  cfg      | in        | cfg_we_i, cfg_index_i, cfg_wdata_i
//
// a plain entry is stored on its handshake; a last entry is stored and then runs the solve
// a search pass reads each upper-triangle entry in turn through the single store read port
// a rotation fetches the pivot entries, waits on the coefficient unit, rotates each other row,
// skips the pivot rows, leaves the row loop, writes the new diagonal and zeroes the pivot pair
// each result is read from the store once the output register is free or draining
// s_axis_tready is high only in the idle state, entered once the last result is loaded
module jacobi_symmetric_eigen_solver_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // row_index[3:0], col_index[7:4], entry_value[39:8]
  input  logic [jse_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // eigen_index[3:0], eigenvalue[35:4], iterations_used[48:36], zero fill above
  output logic [jse_pkg::OutDataW-1:0]    m_axis_tdata,
  // converged[0]
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [jse_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [jse_pkg::ThrW-1:0]        cfg_wdata_i
);
  import jse_pkg::*;

  state_e state_q, state_d;
  logic [SizeW-1:0] nsz_q, n_q, n_d;
  logic [ThrW-1:0]  thr_q;
  logic [CntW-1:0]  lim_q, lim_d, cnt_q, cnt_d;
  logic             conv_q, conv_d;
  logic [3:0]       ph_q, ph_d;
  logic [SizeW-1:0] si_q, si_d, sj_q, sj_d, ri_q, ri_d, oi_q, oi_d;
  logic             sv_q, sv_d;
  logic [IdxW-1:0]  ti_q, ti_d, tj_q, tj_d, pk_q, pk_d, pl_q, pl_d;
  logic [ValW-1:0]  best_q, best_d;
  logic signed [ValW-1:0] akk_q, akk_d, all_q, all_d, akl_q, akl_d;
  logic signed [ValW-1:0] aik_q, aik_d, ail_q, ail_d, nk_q, nk_d, nl_q, nl_d;
  logic signed [65:0] prod_q;
  logic signed [67:0] acc_q, acc_d;
  logic             ov_q, ov_d, olast_q, olast_d, oconv_q, oconv_d;
  logic [IdxW-1:0]  oidx_q, oidx_d;
  logic [ValW-1:0]  oval_q, oval_d;
  logic [CntW-1:0]  oit_q, oit_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [ValW-1:0]  wdata, rdata;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [ValW-1:0]  rmag;
  logic [SizeW-1:0] nclamp;
  logic [9:0]       nsq;
  logic [14:0]      ncube;
  logic             coef_start, coef_done;
  coef_t            coef;
  logic             in_acc;
  logic signed [ValW-1:0] acc_sat;

  jse_ram #(.ADDR_W(AddrW), .DATA_W(ValW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  jse_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (coef_start),
    .akk_i   (akk_q),
    .all_i   (all_q),
    .akl_i   ($signed(rdata)),
    .done_o  (coef_done),
    .coef_o  (coef)
  );

  // round to Q16.16 (halves up) and saturate
  function automatic logic signed [ValW-1:0] rnd_sat(input logic signed [67:0] a);
    logic signed [67:0] y;
    logic signed [37:0] z;
    y = a + 68'sd536870912;
    z = 38'(y >>> 30);
    if (z > 38'sd2147483647) begin
      rnd_sat = 32'sh7fff_ffff;
    end else if (z < -38'sd2147483648) begin
      rnd_sat = 32'sh8000_0000;
    end else begin
      rnd_sat = z[31:0];
    end
  endfunction

  // shared signed multiplier, registered every cycle
  assign mul_p   = mul_a * mul_b;
  assign acc_sat = rnd_sat(acc_q);
  assign rmag    = rdata[ValW-1] ? ValW'(-$signed(rdata)) : rdata;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // size clamp and rotation limit
  always_comb begin
    if (nsz_q < SizeW'(2)) begin
      nclamp = SizeW'(2);
    end else if (nsz_q > SizeW'(MaxN)) begin
      nclamp = SizeW'(MaxN);
    end else begin
      nclamp = nsz_q;
    end
    nsq   = 10'(nclamp) * 10'(nclamp);
    ncube = 15'(nsq) * 15'(nclamp);
  end

  // main sequencer
  always_comb begin
    state_d = state_q;
    n_d = n_q; lim_d = lim_q; cnt_d = cnt_q; conv_d = conv_q;
    ph_d = ph_q; si_d = si_q; sj_d = sj_q; ri_d = ri_q; oi_d = oi_q;
    sv_d = 1'b0; ti_d = ti_q; tj_d = tj_q; pk_d = pk_q; pl_d = pl_q;
    best_d = best_q;
    akk_d = akk_q; all_d = all_q; akl_d = akl_q; aik_d = aik_q; ail_d = ail_q;
    nk_d = nk_q; nl_d = nl_q; acc_d = acc_q;
    ov_d = ov_q; olast_d = olast_q; oconv_d = oconv_q;
    oidx_d = oidx_q; oval_d = oval_q; oit_d = oit_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    mul_a = '0; mul_b = '0;
    coef_start = 1'b0;

    // output register drains on handshake
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    // pivot compare of the entry read last cycle
    if (sv_q && rmag > best_q) begin
      best_d = rmag;
      pk_d   = ti_q;
      pl_d   = tj_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          we    = 1'b1;
          waddr = {s_axis_tdata[3:0], s_axis_tdata[7:4]};
          wdata = s_axis_tdata[39:8];
          if (s_axis_tlast) begin
            n_d    = nclamp;
            lim_d  = ncube[CntW-1:0];
            cnt_d  = '0;
            si_d   = '0;
            sj_d   = SizeW'(1);
            best_d = '0;
            pk_d   = '0;
            pl_d   = IdxW'(1);
            state_d = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        raddr = {si_q[IdxW-1:0], sj_q[IdxW-1:0]};
        sv_d  = 1'b1;
        ti_d  = si_q[IdxW-1:0];
        tj_d  = sj_q[IdxW-1:0];
        if (sj_q + SizeW'(1) == n_q) begin
          if (si_q + SizeW'(2) == n_q) begin
            state_d = ST_SDRAIN;
          end else begin
            si_d = si_q + SizeW'(1);
            sj_d = si_q + SizeW'(2);
          end
        end else begin
          sj_d = sj_q + SizeW'(1);
        end
      end
      ST_SDRAIN: state_d = ST_SQ;
      ST_SQ: begin
        mul_a = {1'b0, best_q};
        mul_b = {1'b0, best_q};
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (prod_q <= $signed({33'd0, thr_q}) || cnt_q >= lim_q) begin
          conv_d  = prod_q <= $signed({33'd0, thr_q});
          oi_d    = '0;
          state_d = ST_ORD;
        end else begin
          ph_d    = '0;
          state_d = ST_RLD;
        end
      end
      // fetch pivot entries and start the coefficient unit
      ST_RLD: begin
        ph_d = ph_q + 4'd1;
        unique case (ph_q)
          4'd0: raddr = {pk_q, pk_q};
          4'd1: begin
            raddr = {pl_q, pl_q};
            akk_d = rdata;
          end
          4'd2: begin
            raddr = {pk_q, pl_q};
            all_d = rdata;
          end
          default: begin
            akl_d      = rdata;
            coef_start = 1'b1;
            state_d    = ST_COEF;
          end
        endcase
      end
      ST_COEF: begin
        if (coef_done) begin
          ri_d    = '0;
          ph_d    = '0;
          state_d = ST_ROT;
        end
      end
      // rotate pivot rows and columns, one row index at a time
      ST_ROT: begin
        if (ri_q == n_q) begin
          ph_d    = '0;
          state_d = ST_DIAG;
        end else if (ri_q[IdxW-1:0] == pk_q || ri_q[IdxW-1:0] == pl_q) begin
          ri_d = ri_q + SizeW'(1);
        end else begin
          ph_d = ph_q + 4'd1;
          unique case (ph_q)
            4'd0: raddr = {ri_q[IdxW-1:0], pk_q};
            4'd1: begin
              raddr = {ri_q[IdxW-1:0], pl_q};
              aik_d = rdata;
            end
            4'd2: ail_d = rdata;
            4'd3: begin
              mul_a = {aik_q[ValW-1], aik_q};
              mul_b = {coef.c[ValW-1], coef.c};
            end
            4'd4: begin
              acc_d = 68'(prod_q);
              mul_a = {ail_q[ValW-1], ail_q};
              mul_b = {coef.s[ValW-1], coef.s};
            end
            4'd5: begin
              acc_d = acc_q - 68'(prod_q);
              mul_a = {ail_q[ValW-1], ail_q};
              mul_b = {coef.c[ValW-1], coef.c};
            end
            4'd6: begin
              nk_d  = acc_sat;
              acc_d = 68'(prod_q);
              mul_a = {aik_q[ValW-1], aik_q};
              mul_b = {coef.s[ValW-1], coef.s};
            end
            4'd7: acc_d = acc_q + 68'(prod_q);
            4'd8: begin
              nl_d  = acc_sat;
              we    = 1'b1;
              waddr = {ri_q[IdxW-1:0], pk_q};
              wdata = nk_q;
            end
            4'd9: begin
              we    = 1'b1;
              waddr = {ri_q[IdxW-1:0], pl_q};
              wdata = nl_q;
            end
            4'd10: begin
              we    = 1'b1;
              waddr = {pk_q, ri_q[IdxW-1:0]};
              wdata = nk_q;
            end
            default: begin
              we    = 1'b1;
              waddr = {pl_q, ri_q[IdxW-1:0]};
              wdata = nl_q;
              ph_d  = '0;
              ri_d  = ri_q + SizeW'(1);
            end
          endcase
        end
      end
      // new pivot diagonal, zeroed pivot pair
      ST_DIAG: begin
        ph_d = ph_q + 4'd1;
        unique case (ph_q)
          4'd0: begin
            mul_a = {akk_q[ValW-1], akk_q};
            mul_b = {coef.c2[ValW-1], coef.c2};
          end
          4'd1: begin
            acc_d = 68'(prod_q);
            mul_a = {akl_q[ValW-1], akl_q};
            mul_b = {coef.cs[ValW-1], coef.cs};
          end
          4'd2: begin
            acc_d = acc_q - (68'(prod_q) <<< 1);
            mul_a = {all_q[ValW-1], all_q};
            mul_b = {coef.s2[ValW-1], coef.s2};
          end
          4'd3: begin
            acc_d = acc_q + 68'(prod_q);
            mul_a = {all_q[ValW-1], all_q};
            mul_b = {coef.c2[ValW-1], coef.c2};
          end
          4'd4: begin
            we    = 1'b1;
            waddr = {pk_q, pk_q};
            wdata = acc_sat;
            acc_d = 68'(prod_q);
            mul_a = {akl_q[ValW-1], akl_q};
            mul_b = {coef.cs[ValW-1], coef.cs};
          end
          4'd5: begin
            acc_d = acc_q + (68'(prod_q) <<< 1);
            mul_a = {akk_q[ValW-1], akk_q};
            mul_b = {coef.s2[ValW-1], coef.s2};
          end
          4'd6: acc_d = acc_q + 68'(prod_q);
          4'd7: begin
            we    = 1'b1;
            waddr = {pl_q, pl_q};
            wdata = acc_sat;
          end
          4'd8: begin
            we    = 1'b1;
            waddr = {pk_q, pl_q};
            wdata = '0;
          end
          default: begin
            we     = 1'b1;
            waddr  = {pl_q, pk_q};
            wdata  = '0;
            cnt_d  = cnt_q + CntW'(1);
            si_d   = '0;
            sj_d   = SizeW'(1);
            best_d = '0;
            pk_d   = '0;
            pl_d   = IdxW'(1);
            state_d = ST_SRCH;
          end
        endcase
      end
      // read one diagonal entry once the output register is free or draining
      ST_ORD: begin
        if (!ov_q || m_axis_tready) begin
          raddr   = {oi_q[IdxW-1:0], oi_q[IdxW-1:0]};
          state_d = ST_OLD;
        end
      end
      ST_OLD: begin
        ov_d    = 1'b1;
        oidx_d  = oi_q[IdxW-1:0];
        oval_d  = rdata;
        oit_d   = cnt_q;
        oconv_d = conv_q;
        olast_d = (oi_q + SizeW'(1) == n_q);
        if (oi_q + SizeW'(1) == n_q) begin
          state_d = ST_IDLE;
        end else begin
          oi_d    = oi_q + SizeW'(1);
          state_d = ST_ORD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result port
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, oit_q, oval_q, oidx_q};
  assign m_axis_tuser  = oconv_q;
  assign m_axis_tlast  = olast_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nsz_q <= SizeW'(MaxN);
      thr_q <= ThrW'(43);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MATRIX_SIZE) begin
        nsz_q <= cfg_wdata_i[SizeW-1:0];
      end else if (cfg_index_i == CFG_THRESHOLD) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      sv_q    <= 1'b0;
      cnt_q   <= '0;
      pk_q    <= '0;
      pl_q    <= IdxW'(1);
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      sv_q    <= sv_d;
      cnt_q   <= cnt_d;
      pk_q    <= pk_d;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    lim_q   <= lim_d;
    conv_q  <= conv_d;
    si_q    <= si_d;
    sj_q    <= sj_d;
    ri_q    <= ri_d;
    oi_q    <= oi_d;
    ti_q    <= ti_d;
    tj_q    <= tj_d;
    best_q  <= best_d;
    akk_q   <= akk_d;
    all_q   <= all_d;
    akl_q   <= akl_d;
    aik_q   <= aik_d;
    ail_q   <= ail_d;
    nk_q    <= nk_d;
    nl_q    <= nl_d;
    acc_q   <= acc_d;
    prod_q  <= mul_p;
    olast_q <= olast_d;
    oconv_q <= oconv_d;
    oidx_q  <= oidx_d;
    oval_q  <= oval_d;
    oit_q   <= oit_d;
  end

endmodule
